/* rtl/whp_pkg.sv */
// Shared types and constants for the WAV header chunk parser.
package whp_pkg;

    // Byte positions and size limits of the WAV layout
    localparam int RIFF_HDR_BYTES = 12;
    localparam int MIN_FILE_BYTES = 44;
    localparam int MIN_FMT_BYTES  = 16;
    localparam int MS_PER_SEC     = 1000;

    // Chunk ids as they appear in file order, first byte most significant
    localparam logic [31:0] ID_FMT  = 32'h666D_7420;
    localparam logic [31:0] ID_DATA = 32'h6461_7461;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_NO_FMT     = 3'd2,
        ST_BAD_FMT    = 3'd3,
        ST_NO_DATA    = 3'd4,
        ST_EMPTY      = 3'd5,
        ST_BAD_LAYOUT = 3'd6,
        ST_NOT_PCM    = 3'd7
    } status_t;

    // Dividend of the duration divide: 32-bit length times 1000
    localparam int PROD_W    = 42;
    localparam int DIV_CNT_W = 6;

    // Controller to datapath commands
    typedef struct packed {
        logic take;     // byte transfer this cycle
        logic eval;     // resolve status and length, clear parse state
        logic mul;      // load dividend and divisor
        logic step;     // one divide iteration
        logic load;     // move the result into the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_seen; // final byte of a file transferred
        logic div_done;  // last divide iteration running
        logic out_busy;  // output register holds an untaken result
    } sts_t;

endpackage

/* rtl/whp_if.sv */
// Byte stream and result channel interfaces of the WAV header chunk parser.
interface whp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       is_last;

    modport source (output valid, output byte_value, output is_last, input ready);
    modport sink   (input valid, input byte_value, input is_last, output ready);
endinterface

interface whp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [1:0]  sample_format;
    logic [31:0] sample_rate;
    logic [31:0] data_offset;
    logic [31:0] data_length;
    logic [31:0] duration_ms;

    modport source (
        output valid, output status, output sample_format, output sample_rate,
        output data_offset, output data_length, output duration_ms, input ready
    );
    modport sink (
        input valid, input status, input sample_format, input sample_rate,
        input data_offset, input data_length, input duration_ms, output ready
    );
endinterface

/* rtl/wav_header_chunk_parser_core.sv */
// Top level of the WAV header chunk parser: controller plus datapath.
//
// Takes a WAV file one byte per transfer on file_bytes, is_last marking the
// final byte, and sends one summary on parse_result per file. While a file
// streams in, a byte is taken every cycle that file_bytes offers one. After
// the final byte the block stops taking bytes while it resolves status and
// length, forms length*1000 and the byte rate, runs the bit-serial duration
// divider (one quotient bit per cycle over the 42-bit dividend) and then
// loads the output register. A summary waiting in the output register does
// not hold up the next file until its own result is ready to load. The byte
// counter is COUNT_WIDTH bits and saturates.
module wav_header_chunk_parser_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    whp_byte_if.sink     file_bytes,
    whp_result_if.source parse_result
);

    whp_pkg::cmd_t cmd;
    whp_pkg::sts_t sts;
    logic          in_ready;

    assign file_bytes.ready = in_ready;

    whp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (file_bytes.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    whp_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_value (file_bytes.byte_value),
        .is_last    (file_bytes.is_last),
        .cmd        (cmd),
        .sts        (sts),
        .result     (parse_result)
    );

endmodule

/* rtl/whp_ctrl.sv */
// Sequencing state machine of the WAV header chunk parser.
module whp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  whp_pkg::sts_t sts,
    output whp_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_RUN,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;

    // Decode commands from the current state
    always_comb
    begin
        cmd      = '0;
        cmd.take = in_ready_reg && in_valid;
        cmd.eval = (state_reg == S_EVAL);
        cmd.mul  = (state_reg == S_MUL);
        cmd.step = (state_reg == S_DIV);
        cmd.load = (state_reg == S_LOAD) && !sts.out_busy;
    end

    // Advance through parse, evaluate, multiply, divide and result load
    always_comb
    begin
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        unique case (state_reg)
            S_RUN:
            begin
                if (sts.last_seen)
                begin
                    state_next    = S_EVAL;
                    in_ready_next = 1'b0;
                end
            end
            S_EVAL:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (!sts.out_busy)
                begin
                    state_next    = S_RUN;
                    in_ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next    = S_RUN;
                in_ready_next = 1'b1;
            end
        endcase
    end

    // Hold state and the registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_RUN;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;

endmodule

/* rtl/whp_datapath.sv */
// Chunk walk registers, result evaluation, duration divider and output register.
module whp_datapath #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    byte_value,
    input  logic          is_last,
    input  whp_pkg::cmd_t cmd,
    output whp_pkg::sts_t sts,
    whp_result_if.source  result
);

    localparam int CW = COUNT_WIDTH;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    typedef enum logic [2:0] {
        PH_FMT_HDR,
        PH_FMT_SKIP,
        PH_FMT_BODY,
        PH_DATA_HDR,
        PH_DATA_SKIP,
        PH_DATA_BODY,
        PH_FAILED
    } phase_t;

    // Parse state
    logic [CW-1:0]    cnt_reg, cnt_next;
    phase_t           phase_reg, phase_next;
    logic [55:0]      hdr_reg, hdr_next;
    logic [2:0]       fill_reg, fill_next;
    logic [31:0]      skip_reg, skip_next;
    logic [4:0]       idx_reg, idx_next;
    logic [15:0]      tag_reg, tag_next;
    logic [15:0]      chan_reg, chan_next;
    logic [31:0]      rate_reg, rate_next;
    logic [15:0]      bits_reg, bits_next;
    logic [CW-1:0]    start_reg, start_next;
    logic [31:0]      decl_reg, decl_next;
    whp_pkg::status_t fail_reg, fail_next;

    // Evaluated result
    whp_pkg::status_t res_status_reg;
    logic [1:0]       res_fmt_reg;
    logic [31:0]      res_rate_reg;
    logic [31:0]      res_off_reg;
    logic [31:0]      res_len_reg;

    // Divider
    logic [whp_pkg::PROD_W-1:0]    dvd_reg;
    logic [31:0]                   dvs_reg;
    logic [31:0]                   rem_reg;
    logic [whp_pkg::DIV_CNT_W-1:0] dcnt_reg;

    // Output register
    logic             out_valid_reg;
    whp_pkg::status_t out_status_reg;
    logic [1:0]       out_fmt_reg;
    logic [31:0]      out_rate_reg;
    logic [31:0]      out_off_reg;
    logic [31:0]      out_len_reg;
    logic [31:0]      out_dur_reg;

    logic [63:0] hdr_full;
    logic [31:0] hdr_id;
    logic [31:0] hdr_size;
    logic        hdr_done;
    logic        cnt_past_riff;

    assign hdr_full      = {hdr_reg, byte_value};
    assign hdr_id        = hdr_full[63:32];
    assign hdr_size      = {hdr_full[7:0], hdr_full[15:8], hdr_full[23:16], hdr_full[31:24]};
    assign hdr_done      = (fill_reg == 3'd7);
    assign cnt_past_riff = (cnt_reg >= CW'(whp_pkg::RIFF_HDR_BYTES));

    // Walk the chunk headers one byte per transfer
    always_comb
    begin
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        hdr_next   = hdr_reg;
        fill_next  = fill_reg;
        skip_next  = skip_reg;
        idx_next   = idx_reg;
        tag_next   = tag_reg;
        chan_next  = chan_reg;
        rate_next  = rate_reg;
        bits_next  = bits_reg;
        start_next = start_reg;
        decl_next  = decl_reg;
        fail_next  = fail_reg;
        if (cmd.eval)
        begin
            cnt_next   = '0;
            phase_next = PH_FMT_HDR;
            hdr_next   = '0;
            fill_next  = '0;
            skip_next  = '0;
            idx_next   = '0;
            tag_next   = '0;
            chan_next  = '0;
            rate_next  = '0;
            bits_next  = '0;
            start_next = '0;
            decl_next  = '0;
            fail_next  = whp_pkg::ST_OK;
        end
        else if (cmd.take)
        begin
            if (cnt_reg != CNT_MAX)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            case (phase_reg)
                PH_FMT_HDR:
                begin
                    if (cnt_past_riff)
                    begin
                        hdr_next  = hdr_full[55:0];
                        fill_next = fill_reg + 1'b1;
                        if (hdr_done)
                        begin
                            if (hdr_id == whp_pkg::ID_FMT)
                            begin
                                if (is_last)
                                begin
                                    phase_next = PH_FAILED;
                                    fail_next  = whp_pkg::ST_NO_FMT;
                                end
                                else if (hdr_size < 32'(whp_pkg::MIN_FMT_BYTES))
                                begin
                                    phase_next = PH_FAILED;
                                    fail_next  = whp_pkg::ST_BAD_FMT;
                                end
                                else
                                begin
                                    skip_next  = hdr_size;
                                    idx_next   = '0;
                                    phase_next = PH_FMT_BODY;
                                end
                            end
                            else if (hdr_size != 32'd0)
                            begin
                                skip_next  = hdr_size;
                                phase_next = PH_FMT_SKIP;
                            end
                        end
                    end
                end
                PH_FMT_SKIP, PH_DATA_SKIP:
                begin
                    skip_next = skip_reg - 1'b1;
                    if (skip_reg == 32'd1)
                    begin
                        phase_next = (phase_reg == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
                    end
                end
                PH_FMT_BODY:
                begin
                    // Capture by offset inside the fmt chunk
                    case (idx_reg)
                        5'd0:  tag_next[7:0]    = byte_value;
                        5'd1:  tag_next[15:8]   = byte_value;
                        5'd2:  chan_next[7:0]   = byte_value;
                        5'd3:  chan_next[15:8]  = byte_value;
                        5'd4:  rate_next[7:0]   = byte_value;
                        5'd5:  rate_next[15:8]  = byte_value;
                        5'd6:  rate_next[23:16] = byte_value;
                        5'd7:  rate_next[31:24] = byte_value;
                        5'd14: bits_next[7:0]   = byte_value;
                        5'd15: bits_next[15:8]  = byte_value;
                        default: ;
                    endcase
                    if (idx_reg != 5'd16)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                    skip_next = skip_reg - 1'b1;
                    if (skip_reg == 32'd1)
                    begin
                        phase_next = PH_DATA_HDR;
                    end
                end
                PH_DATA_HDR:
                begin
                    hdr_next  = hdr_full[55:0];
                    fill_next = fill_reg + 1'b1;
                    if (hdr_done)
                    begin
                        if (hdr_id == whp_pkg::ID_DATA)
                        begin
                            if (is_last)
                            begin
                                phase_next = PH_FAILED;
                                fail_next  = whp_pkg::ST_NO_DATA;
                            end
                            else
                            begin
                                decl_next  = hdr_size;
                                start_next = cnt_next;
                                phase_next = PH_DATA_BODY;
                            end
                        end
                        else if (hdr_size != 32'd0)
                        begin
                            skip_next  = hdr_size;
                            phase_next = PH_DATA_SKIP;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Resolve the first failure and the clamped data length
    logic [CW-1:0]    avail;
    logic [31:0]      len_sel;
    logic             layout_ok;
    whp_pkg::status_t status_sel;

    always_comb
    begin
        avail     = cnt_reg - start_reg;
        len_sel   = (decl_reg > 32'(avail)) ? 32'(avail) : decl_reg;
        layout_ok = (chan_reg == 16'd1 || chan_reg == 16'd2) &&
                    (bits_reg == 16'd8 || bits_reg == 16'd16);
        if (cnt_reg < CW'(whp_pkg::MIN_FILE_BYTES))
        begin
            status_sel = whp_pkg::ST_SHORT;
        end
        else
        begin
            case (phase_reg)
                PH_FAILED:                status_sel = fail_reg;
                PH_FMT_HDR, PH_FMT_SKIP:  status_sel = whp_pkg::ST_NO_FMT;
                PH_FMT_BODY:              status_sel = whp_pkg::ST_BAD_FMT;
                PH_DATA_BODY:
                begin
                    if (len_sel == 32'd0)
                    begin
                        status_sel = whp_pkg::ST_EMPTY;
                    end
                    else if (!layout_ok)
                    begin
                        status_sel = whp_pkg::ST_BAD_LAYOUT;
                    end
                    else if (tag_reg != 16'd1)
                    begin
                        status_sel = whp_pkg::ST_NOT_PCM;
                    end
                    else
                    begin
                        status_sel = whp_pkg::ST_OK;
                    end
                end
                default:                  status_sel = whp_pkg::ST_NO_DATA;
            endcase
        end
    end

    // Divider step: shift one dividend bit into the remainder
    logic [32:0] rem_shift;
    logic        rem_ge;
    logic [1:0]  bps_shift;

    assign rem_shift = {rem_reg, dvd_reg[whp_pkg::PROD_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, dvs_reg});
    assign bps_shift = {1'b0, res_fmt_reg[1]} + {1'b0, res_fmt_reg[0]};

    // Hold parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            phase_reg <= PH_FMT_HDR;
            hdr_reg   <= '0;
            fill_reg  <= '0;
            skip_reg  <= '0;
            idx_reg   <= '0;
            tag_reg   <= '0;
            chan_reg  <= '0;
            rate_reg  <= '0;
            bits_reg  <= '0;
            start_reg <= '0;
            decl_reg  <= '0;
            fail_reg  <= whp_pkg::ST_OK;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
            fill_reg  <= fill_next;
            skip_reg  <= skip_next;
            idx_reg   <= idx_next;
            tag_reg   <= tag_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            bits_reg  <= bits_next;
            start_reg <= start_next;
            decl_reg  <= decl_next;
            fail_reg  <= fail_next;
        end
    end

    // Capture the evaluated result, zeroed on failure
    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            res_status_reg <= status_sel;
            if (status_sel == whp_pkg::ST_OK)
            begin
                res_fmt_reg  <= {chan_reg == 16'd2, bits_reg == 16'd16};
                res_rate_reg <= rate_reg;
                res_off_reg  <= 32'(start_reg);
                res_len_reg  <= len_sel;
            end
            else
            begin
                res_fmt_reg  <= '0;
                res_rate_reg <= '0;
                res_off_reg  <= '0;
                res_len_reg  <= '0;
            end
        end
    end

    // Load the divide, then run one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.mul)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            dvd_reg <= whp_pkg::PROD_W'(res_len_reg) *
                       whp_pkg::PROD_W'(whp_pkg::MS_PER_SEC);
            dvs_reg <= res_rate_reg << bps_shift;
            rem_reg <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_ge ? 32'(rem_shift - {1'b0, dvs_reg}) : rem_shift[31:0];
            dvd_reg <= {dvd_reg[whp_pkg::PROD_W-2:0], rem_ge};
        end
    end

    // Output register: refill on load, drop valid after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_status_reg <= res_status_reg;
            out_fmt_reg    <= res_fmt_reg;
            out_rate_reg   <= res_rate_reg;
            out_off_reg    <= res_off_reg;
            out_len_reg    <= res_len_reg;
            out_dur_reg    <= (dvs_reg == 32'd0) ? 32'd0 : dvd_reg[31:0];
        end
    end

    assign sts.last_seen = cmd.take && is_last;
    assign sts.div_done  = cmd.step &&
                           (dcnt_reg == whp_pkg::DIV_CNT_W'(whp_pkg::PROD_W - 1));
    assign sts.out_busy  = out_valid_reg && !result.ready;

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.sample_format = out_fmt_reg;
    assign result.sample_rate   = out_rate_reg;
    assign result.data_offset   = out_off_reg;
    assign result.data_length   = out_len_reg;
    assign result.duration_ms   = out_dur_reg;

endmodule

/* sim/testbench.sv */
// Self-checking bench for the WAV header parser: table-driven files, then random files.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 8;
    localparam int DIRECTED_N       = 26;
    localparam int TOTAL_BYTES      = 1950;
    localparam int MIN_RANDOM_FILES = 4;
    localparam int PRESSURE_AFTER   = 12;
    localparam int PRESSURE_CYCLES  = 600;
    localparam int DRAIN_CYCLES     = 120;
    localparam int MAX_REPORTS      = 10;
    localparam int TIMEOUT_NS       = 6_000_000;
    localparam int MAX_BODY_BYTES   = 64;
    localparam int MAX_FMT_WRITTEN  = 40;

    // Walk states of the header predictor
    typedef enum logic [2:0] {
        SCAN_FMT_HDR,
        SKIP_PRE_FMT,
        READ_FMT,
        SCAN_DATA_HDR,
        SKIP_PRE_DATA,
        IN_DATA,
        PARSE_FAILED
    } walk_phase_t;

    // One per-file summary as the block reports it
    typedef struct {
        whp_pkg::status_t status;
        logic [1:0]       sample_format;
        logic [31:0]      sample_rate;
        logic [31:0]      data_offset;
        logic [31:0]      data_length;
        logic [31:0]      duration_ms;
    } wav_summary_t;

    // Recipe for one file; want other than ST_OK means the status is typed in
    typedef struct {
        int unsigned      noise_len;
        int unsigned      n_pre;
        bit               data_first;
        logic [31:0]      junk_size;
        bit               has_fmt;
        logic [31:0]      fmt_size;
        logic [15:0]      tag;
        logic [15:0]      chans;
        logic [15:0]      bits;
        logic [31:0]      rate;
        int unsigned      n_mid;
        bit               fmt_again;
        bit               has_data;
        logic [31:0]      data_size;
        int unsigned      data_bytes;
        int unsigned      cut;
        whp_pkg::status_t want;
    } wav_file_t;

    logic clk = 1'b0;
    logic rst_n;

    whp_byte_if   bytes_ch ();
    whp_result_if result_ch ();

    wav_header_chunk_parser_core #(
        .COUNT_WIDTH (32)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .file_bytes   (bytes_ch),
        .parse_result (result_ch)
    );

    // Predictor state
    logic [31:0]      file_pos;
    walk_phase_t      phase;
    logic [63:0]      hdr_shift;
    int unsigned      hdr_fill;
    logic [31:0]      skip_left;
    logic [31:0]      fmt_len;
    logic [15:0]      fmt_tag;
    logic [15:0]      fmt_chans;
    logic [31:0]      fmt_rate;
    logic [15:0]      fmt_bits;
    logic [31:0]      data_start;
    logic [31:0]      data_decl;
    whp_pkg::status_t fail_code;

    wav_summary_t summary_q [$];
    logic [7:0]   file_q [$];
    wav_file_t    directed_files [DIRECTED_N];
    wav_summary_t seen;
    wav_summary_t want;
    int           mismatch_count = 0;
    int           results_seen = 0;
    bit           pressure_done = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic bit chance(int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Mostly short idle stretches, a few long ones
    function automatic int unsigned idle_cycles();
        return chance(85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    function automatic wav_file_t wav_row(
        logic [31:0] n_pre, bit data_first, logic [31:0] junk, bit has_fmt,
        logic [31:0] fmt_size, logic [31:0] tag, logic [31:0] chans, logic [31:0] bits,
        logic [31:0] rate, logic [31:0] n_mid, bit fmt_again, bit has_data,
        logic [31:0] data_size, logic [31:0] data_bytes, logic [31:0] cut,
        whp_pkg::status_t want
    );
        wav_file_t f;
        f.noise_len  = 0;
        f.n_pre      = n_pre;
        f.data_first = data_first;
        f.junk_size  = junk;
        f.has_fmt    = has_fmt;
        f.fmt_size   = fmt_size;
        f.tag        = 16'(tag);
        f.chans      = 16'(chans);
        f.bits       = 16'(bits);
        f.rate       = rate;
        f.n_mid      = n_mid;
        f.fmt_again  = fmt_again;
        f.has_data   = has_data;
        f.data_size  = data_size;
        f.data_bytes = data_bytes;
        f.cut        = cut;
        f.want       = want;
        return f;
    endfunction

    task automatic clear_parse_state();
        file_pos   = '0;
        phase      = SCAN_FMT_HDR;
        hdr_shift  = '0;
        hdr_fill   = 0;
        skip_left  = '0;
        fmt_len    = '0;
        fmt_tag    = '0;
        fmt_chans  = '0;
        fmt_rate   = '0;
        fmt_bits   = '0;
        data_start = '0;
        data_decl  = '0;
        fail_code  = whp_pkg::ST_OK;
    endtask

    task automatic mark_failed(whp_pkg::status_t code);
        phase     = PARSE_FAILED;
        fail_code = code;
    endtask

    // Advance the chunk walk by one byte; on the final byte form the summary
    task automatic parse_wav_byte(input logic [7:0] b, input bit last,
                                  output bit done, output wav_summary_t s);
        logic [31:0]      pos;
        logic [31:0]      sz;
        logic [31:0]      idx;
        logic [31:0]      avail;
        logic [31:0]      len;
        logic [31:0]      bps;
        logic [63:0]      prod;
        bit               hdr_full;
        whp_pkg::status_t st;
        pos = file_pos;
        if (file_pos != '1)
            file_pos = file_pos + 1;
        hdr_full = 1'b0;
        if ((phase == SCAN_FMT_HDR && pos >= whp_pkg::RIFF_HDR_BYTES) ||
            phase == SCAN_DATA_HDR)
        begin
            hdr_shift = {hdr_shift[55:0], b};
            hdr_fill++;
            if (hdr_fill == 8)
            begin
                hdr_fill = 0;
                hdr_full = 1'b1;
            end
        end
        sz = {hdr_shift[7:0], hdr_shift[15:8], hdr_shift[23:16], hdr_shift[31:24]};
        case (phase)
            SCAN_FMT_HDR:
                if (hdr_full)
                begin
                    if (hdr_shift[63:32] == whp_pkg::ID_FMT)
                    begin
                        if (last)
                            mark_failed(whp_pkg::ST_NO_FMT);
                        else if (sz < whp_pkg::MIN_FMT_BYTES)
                            mark_failed(whp_pkg::ST_BAD_FMT);
                        else
                        begin
                            fmt_len   = sz;
                            skip_left = sz;
                            phase     = READ_FMT;
                        end
                    end
                    else if (sz != 0)
                    begin
                        skip_left = sz;
                        phase     = SKIP_PRE_FMT;
                    end
                end
            SKIP_PRE_FMT, SKIP_PRE_DATA:
            begin
                skip_left = skip_left - 1;
                if (skip_left == 0)
                    phase = (phase == SKIP_PRE_FMT) ? SCAN_FMT_HDR : SCAN_DATA_HDR;
            end
            READ_FMT:
            begin
                idx = fmt_len - skip_left;
                case (idx)
                    32'd0:  fmt_tag[7:0]    = b;
                    32'd1:  fmt_tag[15:8]   = b;
                    32'd2:  fmt_chans[7:0]  = b;
                    32'd3:  fmt_chans[15:8] = b;
                    32'd4:  fmt_rate[7:0]   = b;
                    32'd5:  fmt_rate[15:8]  = b;
                    32'd6:  fmt_rate[23:16] = b;
                    32'd7:  fmt_rate[31:24] = b;
                    32'd14: fmt_bits[7:0]   = b;
                    32'd15: fmt_bits[15:8]  = b;
                    default: ;
                endcase
                skip_left = skip_left - 1;
                if (skip_left == 0)
                    phase = SCAN_DATA_HDR;
            end
            SCAN_DATA_HDR:
                if (hdr_full)
                begin
                    if (hdr_shift[63:32] == whp_pkg::ID_DATA)
                    begin
                        if (last)
                            mark_failed(whp_pkg::ST_NO_DATA);
                        else
                        begin
                            data_decl  = sz;
                            data_start = file_pos;
                            phase      = IN_DATA;
                        end
                    end
                    else if (sz != 0)
                    begin
                        skip_left = sz;
                        phase     = SKIP_PRE_DATA;
                    end
                end
            default: ;
        endcase

        done = last;
        s    = '{whp_pkg::ST_OK, 2'b0, 32'b0, 32'b0, 32'b0, 32'b0};
        if (last)
        begin
            // Resolve the first failure in status order
            len = '0;
            if (file_pos < whp_pkg::MIN_FILE_BYTES)
                st = whp_pkg::ST_SHORT;
            else if (phase == PARSE_FAILED)
                st = fail_code;
            else if (phase == SCAN_FMT_HDR || phase == SKIP_PRE_FMT)
                st = whp_pkg::ST_NO_FMT;
            else if (phase == READ_FMT)
                st = whp_pkg::ST_BAD_FMT;
            else if (phase != IN_DATA)
                st = whp_pkg::ST_NO_DATA;
            else
            begin
                avail = file_pos - data_start;
                len   = (data_decl > avail) ? avail : data_decl;
                if (len == 0)
                    st = whp_pkg::ST_EMPTY;
                else if ((fmt_chans != 1 && fmt_chans != 2) ||
                         (fmt_bits != 8 && fmt_bits != 16))
                    st = whp_pkg::ST_BAD_LAYOUT;
                else if (fmt_tag != 1)
                    st = whp_pkg::ST_NOT_PCM;
                else
                    st = whp_pkg::ST_OK;
            end
            s.status = st;
            if (st == whp_pkg::ST_OK)
            begin
                bps  = fmt_rate * {16'b0, fmt_chans} * {16'b0, fmt_bits / 16'd8};
                prod = {32'b0, len} * 64'(whp_pkg::MS_PER_SEC);
                s.sample_format = {fmt_chans == 2, fmt_bits == 16};
                s.sample_rate   = fmt_rate;
                s.data_offset   = data_start;
                s.data_length   = len;
                s.duration_ms   = (bps == 0) ? 32'b0 : 32'(prod / {32'b0, bps});
            end
            clear_parse_state();
        end
    endtask

    // Append one byte to the file under construction
    task automatic append_byte(logic [7:0] b);
        file_q = {file_q, b};
    endtask

    task automatic push_random(int unsigned n);
        repeat (n) append_byte(8'($urandom));
    endtask

    // Chunk ids go most significant byte first, sizes little-endian
    task automatic push_id(logic [31:0] id);
        append_byte(id[31:24]);
        append_byte(id[23:16]);
        append_byte(id[15:8]);
        append_byte(id[7:0]);
    endtask

    task automatic push_le32(logic [31:0] v);
        append_byte(v[7:0]);
        append_byte(v[15:8]);
        append_byte(v[23:16]);
        append_byte(v[31:24]);
    endtask

    // Oversized chunks get a short body so the file overruns
    task automatic add_chunk(logic [31:0] id, logic [31:0] size);
        push_id(id);
        push_le32(size);
        push_random((size <= MAX_BODY_BYTES) ? size : 8);
    endtask

    function automatic logic [31:0] foreign_id();
        logic [31:0] id;
        id = $urandom;
        if (id == whp_pkg::ID_FMT || id == whp_pkg::ID_DATA)
            id[0] = ~id[0];
        return id;
    endfunction

    task automatic build_file(input wav_file_t f);
        logic [7:0]  fmt_body [16];
        int unsigned body_len;
        file_q.delete();
        if (f.noise_len != 0)
            push_random(f.noise_len);
        else
        begin
            push_random(whp_pkg::RIFF_HDR_BYTES);
            if (f.data_first)
                add_chunk(whp_pkg::ID_DATA, f.junk_size);
            repeat (f.n_pre) add_chunk(foreign_id(), f.junk_size);
            if (f.has_fmt)
            begin
                push_id(whp_pkg::ID_FMT);
                push_le32(f.fmt_size);
                fmt_body[0]  = f.tag[7:0];
                fmt_body[1]  = f.tag[15:8];
                fmt_body[2]  = f.chans[7:0];
                fmt_body[3]  = f.chans[15:8];
                fmt_body[4]  = f.rate[7:0];
                fmt_body[5]  = f.rate[15:8];
                fmt_body[6]  = f.rate[23:16];
                fmt_body[7]  = f.rate[31:24];
                for (int k = 8; k < 14; k++)
                    fmt_body[k] = 8'($urandom);
                fmt_body[14] = f.bits[7:0];
                fmt_body[15] = f.bits[15:8];
                body_len = (f.fmt_size > MAX_FMT_WRITTEN) ? MAX_FMT_WRITTEN : f.fmt_size;
                for (int k = 0; k < body_len; k++)
                    append_byte((k < 16) ? fmt_body[k] : 8'($urandom));
            end
            if (f.fmt_again)
                add_chunk(whp_pkg::ID_FMT, whp_pkg::MIN_FMT_BYTES);
            repeat (f.n_mid) add_chunk(foreign_id(), f.junk_size);
            if (f.has_data)
            begin
                push_id(whp_pkg::ID_DATA);
                push_le32(f.data_size);
                push_random(f.data_bytes);
            end
            if (f.cut != 0)
                while (file_q.size() > f.cut)
                    void'(file_q.pop_back());
        end
    endtask

    // Mostly well-formed files with random content, some broken, some noise
    task automatic pick_random_file(output wav_file_t f);
        int unsigned kind;
        kind = $urandom_range(0, 99);
        f = wav_row(0, 0, 0, 1, whp_pkg::MIN_FMT_BYTES, 1, 1, 8, 8000, 0, 0, 1, 4, 4, 0,
                    whp_pkg::ST_OK);
        if (kind < 8)
        begin
            f.noise_len = $urandom_range(1, 90);
            return;
        end
        if (chance(40))
            f.n_pre = $urandom_range(1, 2);
        f.junk_size  = chance(15) ? 0 : $urandom_range(1, 12);
        f.data_first = chance(12);
        if (chance(25))
            f.fmt_size = $urandom_range(17, 24);
        f.tag = chance(90) ? 16'd1 : 16'($urandom);
        if (chance(90))
            f.chans = 16'($urandom_range(1, 2));
        else
            f.chans = chance(50) ? 16'($urandom_range(0, 4)) : 16'($urandom);
        if (chance(90))
            f.bits = chance(50) ? 16'd16 : 16'd8;
        else
            f.bits = chance(50) ? 16'($urandom_range(0, 32)) : 16'($urandom);
        case ($urandom_range(0, 2))
            0:
                case ($urandom_range(0, 4))
                    0: f.rate = 8000;
                    1: f.rate = 11025;
                    2: f.rate = 22050;
                    3: f.rate = 44100;
                    default: f.rate = 48000;
                endcase
            1: f.rate = $urandom;
            default: f.rate = $urandom_range(0, 15);
        endcase
        f.n_mid      = chance(30) ? $urandom_range(1, 2) : 0;
        f.fmt_again  = chance(10);
        f.data_bytes = chance(90) ? $urandom_range(1, 16) : $urandom_range(0, 40);
        case ($urandom_range(0, 9))
            7: f.data_size = 0;
            8: f.data_size = $urandom;
            9: f.data_size = $urandom_range(0, f.data_bytes);
            default: f.data_size = f.data_bytes;
        endcase
        if (kind >= 80)
        begin
            case ($urandom_range(0, 5))
                0: f.cut = $urandom_range(1, 80);
                1: f.has_fmt = 1'b0;
                2: f.has_data = 1'b0;
                3: f.fmt_size = chance(50) ? $urandom_range(0, 15) : $urandom;
                4:
                begin
                    f.junk_size = $urandom;
                    if (chance(50))
                        f.n_pre = 1;
                    else
                        f.n_mid = 1;
                end
                default: f.cut = $urandom_range(40, 60);
            endcase
        end
    endtask

    // Offer every byte of one file, with or without idle gaps
    task automatic send_file(input wav_file_t f);
        bit           calm;
        bit           done;
        bit           last;
        wav_summary_t s;
        build_file(f);
        calm = chance(30);
        for (int i = 0; i < file_q.size(); i++)
        begin
            if (!calm && chance(25))
            begin
                bytes_ch.valid <= 1'b0;
                repeat (idle_cycles()) @(posedge clk);
            end
            last = (i == file_q.size() - 1);
            bytes_ch.valid      <= 1'b1;
            bytes_ch.byte_value <= file_q[i];
            bytes_ch.is_last    <= last;
            do
                @(posedge clk);
            while (!bytes_ch.ready);
            parse_wav_byte(file_q[i], last, done, s);
            if (done)
            begin
                if (f.want != whp_pkg::ST_OK)
                    s = '{f.want, 2'b0, 32'b0, 32'b0, 32'b0, 32'b0};
                summary_q = {summary_q, s};
            end
        end
    endtask

    // Compare each summary transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_ch.valid && result_ch.ready)
        begin
            results_seen <= results_seen + 1;
            seen.status        = whp_pkg::status_t'(result_ch.status);
            seen.sample_format = result_ch.sample_format;
            seen.sample_rate   = result_ch.sample_rate;
            seen.data_offset   = result_ch.data_offset;
            seen.data_length   = result_ch.data_length;
            seen.duration_ms   = result_ch.duration_ms;
            if (summary_q.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: summary with none expected: status %0d", $time,
                             seen.status);
                mismatch_count++;
            end
            else
            begin
                want = summary_q.pop_front();
                if (seen.status !== want.status ||
                    seen.sample_format !== want.sample_format ||
                    seen.sample_rate !== want.sample_rate ||
                    seen.data_offset !== want.data_offset ||
                    seen.data_length !== want.data_length ||
                    seen.duration_ms !== want.duration_ms)
                begin
                    if (mismatch_count < MAX_REPORTS)
                    begin
                        $display("%0t: expected st %0d fmt %0d rate %h off %0d len %0d ms %0d",
                                 $time, want.status, want.sample_format, want.sample_rate,
                                 want.data_offset, want.data_length, want.duration_ms);
                        $display("%0t:   actual st %0d fmt %0d rate %h off %0d len %0d ms %0d",
                                 $time, seen.status, seen.sample_format, seen.sample_rate,
                                 seen.data_offset, seen.data_length, seen.duration_ms);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Drive result ready: random gaps, one long hold-off to back the block up
    initial
    begin
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!pressure_done && results_seen >= PRESSURE_AFTER)
            begin
                result_ch.ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge clk);
                pressure_done = 1'b1;
            end
            else if (chance(35))
            begin
                result_ch.ready <= 1'b0;
                repeat (idle_cycles()) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Main sequence: reset, directed files, random files, drain
    initial
    begin
        int unsigned sent_bytes;
        int unsigned random_files;
        wav_file_t   f;
        sent_bytes   = 0;
        random_files = 0;
        rst_n               <= 1'b0;
        bytes_ch.valid      <= 1'b0;
        bytes_ch.byte_value <= 8'h00;
        bytes_ch.is_last    <= 1'b0;
        clear_parse_state();

        // Valid layouts, clamping, zero and wrapped divisor, chunks to skip
        directed_files[0]  = wav_row(0, 0, 0, 1, 16, 1, 1, 8, 8000, 0, 0, 1, 4, 4, 0,
                                     whp_pkg::ST_OK);
        directed_files[1]  = wav_row(0, 0, 0, 1, 16, 1, 1, 16, 44100, 0, 0, 1, 10, 10, 0,
                                     whp_pkg::ST_OK);
        directed_files[2]  = wav_row(0, 0, 0, 1, 18, 1, 2, 8, 22050, 0, 0, 1, 6, 6, 0,
                                     whp_pkg::ST_OK);
        directed_files[3]  = wav_row(0, 0, 0, 1, 16, 1, 2, 16, 48000, 0, 0, 1,
                                     32'hFFFF_FFFF, 8, 0, whp_pkg::ST_OK);
        directed_files[4]  = wav_row(0, 0, 0, 1, 16, 1, 1, 8, 11025, 0, 0, 1, 2, 12, 0,
                                     whp_pkg::ST_OK);
        directed_files[5]  = wav_row(0, 0, 0, 1, 16, 1, 2, 16, 32'hFFFF_FFFF, 0, 0, 1,
                                     16, 16, 0, whp_pkg::ST_OK);
        directed_files[6]  = wav_row(0, 0, 0, 1, 16, 1, 1, 16, 0, 0, 0, 1, 4, 4, 0,
                                     whp_pkg::ST_OK);
        directed_files[7]  = wav_row(0, 0, 0, 1, 16, 1, 2, 8, 32'h8000_0000, 0, 0, 1,
                                     4, 4, 0, whp_pkg::ST_OK);
        directed_files[8]  = wav_row(2, 0, 0, 1, 16, 1, 1, 8, 8000, 0, 0, 1, 4, 4, 0,
                                     whp_pkg::ST_OK);
        directed_files[9]  = wav_row(1, 1, 3, 1, 16, 1, 2, 16, 44100, 2, 1, 1, 8, 8, 0,
                                     whp_pkg::ST_OK);
        // Short files, including a single byte and a bad fmt cut short
        directed_files[10] = wav_row(0, 0, 0, 1, 16, 1, 1, 8, 8000, 0, 0, 1, 4, 4, 43,
                                     whp_pkg::ST_SHORT);
        directed_files[11] = wav_row(0, 0, 0, 1, 16, 1, 1, 8, 8000, 0, 0, 1, 4, 4, 1,
                                     whp_pkg::ST_SHORT);
        directed_files[12] = wav_row(0, 0, 0, 1, 15, 1, 1, 8, 8000, 0, 0, 1, 4, 4, 30,
                                     whp_pkg::ST_SHORT);
        // Missing fmt: data first, header on the final byte, overrunning chunk
        directed_files[13] = wav_row(2, 1, 12, 0, 16, 1, 1, 8, 8000, 0, 0, 1, 4, 4, 0,
                                     whp_pkg::ST_NO_FMT);
        directed_files[14] = wav_row(1, 0, 24, 1, 16, 1, 1, 8, 8000, 0, 0, 1, 4, 4, 52,
                                     whp_pkg::ST_NO_FMT);
        directed_files[15] = wav_row(1, 0, 1000, 1, 16, 1, 1, 8, 8000, 0, 0, 1, 4, 4, 0,
                                     whp_pkg::ST_NO_FMT);
        // Bad fmt size: too small, overrunning the file
        directed_files[16] = wav_row(1, 0, 16, 1, 15, 1, 1, 8, 8000, 0, 0, 1, 4, 4, 0,
                                     whp_pkg::ST_BAD_FMT);
        directed_files[17] = wav_row(0, 0, 0, 1, 1000, 1, 1, 8, 8000, 0, 0, 1, 4, 4, 0,
                                     whp_pkg::ST_BAD_FMT);
        // Missing data, data header on the final byte, empty data
        directed_files[18] = wav_row(0, 0, 16, 1, 16, 1, 1, 8, 8000, 1, 0, 0, 4, 4, 0,
                                     whp_pkg::ST_NO_DATA);
        directed_files[19] = wav_row(0, 0, 0, 1, 16, 1, 1, 8, 8000, 0, 0, 1, 4, 0, 0,
                                     whp_pkg::ST_NO_DATA);
        directed_files[20] = wav_row(0, 0, 0, 1, 16, 1, 1, 8, 8000, 0, 0, 1, 0, 4, 0,
                                     whp_pkg::ST_EMPTY);
        // Layout and tag failures, and which failure wins
        directed_files[21] = wav_row(0, 0, 0, 1, 16, 1, 3, 8, 8000, 0, 0, 1, 4, 4, 0,
                                     whp_pkg::ST_BAD_LAYOUT);
        directed_files[22] = wav_row(0, 0, 0, 1, 16, 1, 1, 24, 8000, 0, 0, 1, 4, 4, 0,
                                     whp_pkg::ST_BAD_LAYOUT);
        directed_files[23] = wav_row(0, 0, 0, 1, 16, 3, 1, 8, 8000, 0, 0, 1, 4, 4, 0,
                                     whp_pkg::ST_NOT_PCM);
        directed_files[24] = wav_row(0, 0, 0, 1, 16, 3, 3, 8, 8000, 0, 0, 1, 4, 4, 0,
                                     whp_pkg::ST_BAD_LAYOUT);
        directed_files[25] = wav_row(0, 0, 0, 1, 16, 1, 3, 8, 8000, 0, 0, 1, 0, 4, 0,
                                     whp_pkg::ST_EMPTY);

        // Hold reset, then release
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
        begin
            send_file(directed_files[i]);
            sent_bytes += file_q.size();
        end

        // Top up with random files until the byte budget is spent and MIN_RANDOM_FILES have gone
        while (sent_bytes < TOTAL_BYTES || random_files < MIN_RANDOM_FILES)
        begin
            pick_random_file(f);
            send_file(f);
            sent_bytes += file_q.size();
            random_files++;
        end
        bytes_ch.valid <= 1'b0;

        // Drain outstanding summaries
        while (summary_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && summary_q.size() == 0)
            $display("** wav_header_chunk_parser_core: PASSED **");
        else
            $display("** wav_header_chunk_parser_core: FAILED **");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(TIMEOUT_NS);
        $display("** wav_header_chunk_parser_core: FAILED **");
        $finish;
    end

endmodule
